// ----- rtl/core/tssm_pkg.sv -----
`default_nettype none
package tssm_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int SPLIT_W = 5;
   localparam int WORD_W = 32;
   localparam int STATUS_W = 2;
   localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(16);
   localparam logic signed [WORD_W-1:0] MINUS_ONE = -WORD_W'(1);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP = 1'b1;

   localparam logic [1:0] SEL_FIRST = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_THIRD = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;   // latch request word
      logic execute;   // pointer update and memory access
   } cmd_type;

endpackage
`default_nettype wire

// ----- rtl/core/three_stacks_shared_memory.sv -----
// Three stacks in one word store, one request at a time.
// Each request goes through accept, store access and response; the response is held
// while it is stalled, and no new request is accepted until it has been taken,
// so the controller holds one request in flight.
// Reset (synchronous): all stacks empty, split point 16 (saturated to DEPTH).
`default_nettype none
module three_stacks_shared_memory #(
   parameter int DEPTH = tssm_pkg::DEPTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_op,
   input  wire  [1:0]                         req_stack_sel,
   input  wire  signed [tssm_pkg::WORD_W-1:0] req_push_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [tssm_pkg::WORD_W-1:0] rsp_pop_value,
   output logic [tssm_pkg::STATUS_W-1:0]      rsp_status,
   input  wire                                csr_write_en,
   input  wire  [tssm_pkg::SPLIT_W-1:0]       csr_write_data
);

   tssm_pkg::cmd_type cmd;

   tssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tssm_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

// ----- rtl/core/tssm_ctrl.sv -----
`default_nettype none
module tssm_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output tssm_pkg::cmd_type  cmd
);

   tssm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tssm_pkg::S_IDLE: begin
            if (req_valid) state_in = tssm_pkg::S_EXEC;
         end
         tssm_pkg::S_EXEC: begin
            state_in = tssm_pkg::S_RESP;
         end
         tssm_pkg::S_RESP: begin
            if (!rsp_stall) state_in = tssm_pkg::S_IDLE;
         end
         default: begin
            state_in = tssm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != tssm_pkg::S_IDLE);
   assign rsp_valid = (state_ff == tssm_pkg::S_RESP);
   assign cmd.capture = (state_ff == tssm_pkg::S_IDLE) && req_valid;
   assign cmd.execute = (state_ff == tssm_pkg::S_EXEC);

endmodule
`default_nettype wire

// ----- rtl/core/tssm_dpath.sv -----
`default_nettype none
module tssm_dpath #(
   parameter int DEPTH = tssm_pkg::DEPTH_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  tssm_pkg::cmd_type                       cmd,
   input  wire                                     req_op,
   input  wire  [1:0]                              req_stack_sel,
   input  wire  signed [tssm_pkg::WORD_W-1:0]      req_push_value,
   input  wire                                     csr_write_en,
   input  wire  [tssm_pkg::SPLIT_W-1:0]            csr_write_data,
   output logic signed [tssm_pkg::WORD_W-1:0]      rsp_pop_value,
   output logic [tssm_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int PW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = (PW > tssm_pkg::SPLIT_W) ? PW : tssm_pkg::SPLIT_W;

   logic [tssm_pkg::WORD_W-1:0] mem [DEPTH];

   logic [PW-1:0] first_ff, second_ff, third_ff, split_ff;
   logic [PW-1:0] first_in, second_in, third_in;
   logic          op_ff;
   logic [1:0]    sel_ff;
   logic [tssm_pkg::WORD_W-1:0] val_ff;
   logic [tssm_pkg::WORD_W-1:0] rd_data_ff;
   logic          pop_ok_ff, pop_ok_in;
   logic [tssm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic          we;
   logic [PW-1:0] addr;

   // split saturated to the memory size
   logic [CW-1:0] csr_split_ext;
   logic [PW-1:0] csr_split_sat;
   logic [PW-1:0] reset_split_sat;

   assign csr_split_ext = CW'(csr_write_data);
   assign csr_split_sat = (csr_split_ext > CW'(DEPTH)) ? PW'(DEPTH) : PW'(csr_split_ext);
   assign reset_split_sat = (CW'(tssm_pkg::SPLIT_RESET) > CW'(DEPTH))
                            ? PW'(DEPTH) : PW'(CW'(tssm_pkg::SPLIT_RESET));

   always_comb begin
      first_in = first_ff;
      second_in = second_ff;
      third_in = third_ff;
      we = 1'b0;
      addr = first_ff;
      pop_ok_in = 1'b0;
      if (op_ff == tssm_pkg::OP_PUSH) begin
         status_in = tssm_pkg::ST_FULL;
         case (sel_ff)
            tssm_pkg::SEL_FIRST: begin
               addr = first_ff;
               if (first_ff < second_ff) begin
                  we = 1'b1;
                  first_in = first_ff + PW'(1);
                  status_in = tssm_pkg::ST_OK;
               end
            end
            tssm_pkg::SEL_SECOND: begin
               addr = second_ff - PW'(1);
               if (second_ff > first_ff) begin
                  we = 1'b1;
                  second_in = second_ff - PW'(1);
                  status_in = tssm_pkg::ST_OK;
               end
            end
            tssm_pkg::SEL_THIRD: begin
               addr = third_ff;
               if (third_ff < PW'(DEPTH)) begin
                  we = 1'b1;
                  third_in = third_ff + PW'(1);
                  status_in = tssm_pkg::ST_OK;
               end
            end
            default: begin
               status_in = tssm_pkg::ST_FULL;
            end
         endcase
      end else begin
         status_in = tssm_pkg::ST_EMPTY;
         case (sel_ff)
            tssm_pkg::SEL_FIRST: begin
               addr = first_ff - PW'(1);
               if (first_ff != '0) begin
                  first_in = first_ff - PW'(1);
                  pop_ok_in = 1'b1;
                  status_in = tssm_pkg::ST_OK;
               end
            end
            tssm_pkg::SEL_SECOND: begin
               addr = second_ff;
               if (second_ff < split_ff) begin
                  second_in = second_ff + PW'(1);
                  pop_ok_in = 1'b1;
                  status_in = tssm_pkg::ST_OK;
               end
            end
            tssm_pkg::SEL_THIRD: begin
               addr = third_ff - PW'(1);
               if (third_ff > split_ff) begin
                  third_in = third_ff - PW'(1);
                  pop_ok_in = 1'b1;
                  status_in = tssm_pkg::ST_OK;
               end
            end
            default: begin
               status_in = tssm_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= reset_split_sat;
         first_ff <= '0;
         second_ff <= reset_split_sat;
         third_ff <= reset_split_sat;
      end else if (csr_write_en) begin
         split_ff <= csr_split_sat;
         first_ff <= '0;
         second_ff <= csr_split_sat;
         third_ff <= csr_split_sat;
      end else if (cmd.execute) begin
         first_ff <= first_in;
         second_ff <= second_in;
         third_ff <= third_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         sel_ff <= req_stack_sel;
         val_ff <= req_push_value;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // single-port word store, registered read
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (we) mem[addr[AW-1:0]] <= val_ff;
         rd_data_ff <= mem[addr[AW-1:0]];
      end
   end

   assign rsp_pop_value = pop_ok_ff ? $signed(rd_data_ff) : tssm_pkg::MINUS_ONE;
   assign rsp_status = status_ff;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_W = tssm_pkg::WORD_W;
   localparam int STATUS_W = tssm_pkg::STATUS_W;
   localparam int SPLIT_W = tssm_pkg::SPLIT_W;
   localparam logic [SPLIT_W-1:0] SPLIT_RESET = tssm_pkg::SPLIT_RESET;
   localparam logic signed [WORD_W-1:0] MINUS_ONE = tssm_pkg::MINUS_ONE;
   localparam logic OP_PUSH = tssm_pkg::OP_PUSH;
   localparam logic OP_POP = tssm_pkg::OP_POP;
   localparam logic [1:0] SEL_FIRST = tssm_pkg::SEL_FIRST;
   localparam logic [1:0] SEL_SECOND = tssm_pkg::SEL_SECOND;
   localparam logic [1:0] SEL_THIRD = tssm_pkg::SEL_THIRD;
   localparam logic [STATUS_W-1:0] ST_OK = tssm_pkg::ST_OK;
   localparam logic [STATUS_W-1:0] ST_FULL = tssm_pkg::ST_FULL;
   localparam logic [STATUS_W-1:0] ST_EMPTY = tssm_pkg::ST_EMPTY;

   localparam int DEPTH = tssm_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam logic [1:0] SEL_NONE = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0]   pop_value;
      logic [STATUS_W-1:0] status;
   } answer_type;

   typedef enum logic [1:0] {
      STEP_ITEM,     // checked against the predictor
      STEP_CHECKED,  // answer typed in below
      STEP_SPLIT     // write split point, value[4:0]
   } step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic              op;
      logic [1:0]        sel;
      logic [WORD_W-1:0] value;
      answer_type        answer;
   } step_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_op;
   logic [1:0] req_stack_sel;
   logic signed [WORD_W-1:0] req_push_value;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_pop_value;
   logic [STATUS_W-1:0] rsp_status;
   logic csr_write_en;
   logic [SPLIT_W-1:0] csr_write_data;

   // predictor state
   logic [WORD_W-1:0] word_store [DEPTH];
   int unsigned first_top;
   int unsigned second_top;
   int unsigned third_top;
   logic [SPLIT_W-1:0] split_point;

   answer_type expected_answers[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   step_row_type directed_steps[$] = '{
      '{STEP_CHECKED, OP_POP,  SEL_FIRST,  32'd0,         '{MINUS_ONE, ST_EMPTY}},
      '{STEP_CHECKED, OP_POP,  SEL_SECOND, 32'd0,         '{MINUS_ONE, ST_EMPTY}},
      '{STEP_CHECKED, OP_POP,  SEL_THIRD,  32'd0,         '{MINUS_ONE, ST_EMPTY}},
      '{STEP_CHECKED, OP_POP,  SEL_NONE,   32'd0,         '{MINUS_ONE, ST_EMPTY}},
      '{STEP_CHECKED, OP_PUSH, SEL_NONE,   32'h1234_5678, '{MINUS_ONE, ST_FULL}},
      '{STEP_CHECKED, OP_PUSH, SEL_FIRST,  32'h8000_0000, '{MINUS_ONE, ST_OK}},
      '{STEP_CHECKED, OP_PUSH, SEL_SECOND, 32'h7fff_ffff, '{MINUS_ONE, ST_OK}},
      '{STEP_CHECKED, OP_PUSH, SEL_THIRD,  32'hffff_ffff, '{MINUS_ONE, ST_OK}},
      '{STEP_CHECKED, OP_POP,  SEL_FIRST,  32'hffff_ffff, '{32'h8000_0000, ST_OK}},
      '{STEP_CHECKED, OP_POP,  SEL_SECOND, 32'h0000_0000, '{32'h7fff_ffff, ST_OK}},
      '{STEP_CHECKED, OP_POP,  SEL_THIRD,  32'h5a5a_a5a5, '{32'hffff_ffff, ST_OK}},
      '{STEP_SPLIT,   OP_PUSH, SEL_FIRST,  32'd0,         '0},
      '{STEP_CHECKED, OP_PUSH, SEL_FIRST,  32'd1,         '{MINUS_ONE, ST_FULL}},
      '{STEP_CHECKED, OP_PUSH, SEL_SECOND, 32'd2,         '{MINUS_ONE, ST_FULL}},
      '{STEP_ITEM,    OP_PUSH, SEL_THIRD,  32'h0f0f_f0f0, '0},
      '{STEP_ITEM,    OP_POP,  SEL_THIRD,  32'd0,         '0},
      '{STEP_SPLIT,   OP_PUSH, SEL_FIRST,  32'd31,        '0},
      '{STEP_ITEM,    OP_PUSH, SEL_THIRD,  32'h0000_0001, '0},
      '{STEP_CHECKED, OP_PUSH, SEL_THIRD,  32'd2,         '{MINUS_ONE, ST_FULL}},
      '{STEP_ITEM,    OP_POP,  SEL_THIRD,  32'd0,         '0},
      '{STEP_SPLIT,   OP_PUSH, SEL_FIRST,  32'd1,         '0},
      '{STEP_ITEM,    OP_PUSH, SEL_SECOND, 32'haaaa_5555, '0},
      '{STEP_CHECKED, OP_PUSH, SEL_FIRST,  32'd3,         '{MINUS_ONE, ST_FULL}},
      '{STEP_CHECKED, OP_POP,  SEL_FIRST,  32'd0,         '{MINUS_ONE, ST_EMPTY}},
      '{STEP_ITEM,    OP_POP,  SEL_SECOND, 32'd0,         '0},
      '{STEP_SPLIT,   OP_PUSH, SEL_FIRST,  32'd1,         '0},
      '{STEP_ITEM,    OP_PUSH, SEL_FIRST,  32'h5555_aaaa, '0},
      '{STEP_CHECKED, OP_PUSH, SEL_SECOND, 32'd4,         '{MINUS_ONE, ST_FULL}},
      '{STEP_ITEM,    OP_POP,  SEL_FIRST,  32'd0,         '0}
   };

   three_stacks_shared_memory #(
      .DEPTH(DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_stack_sel (req_stack_sel),
      .req_push_value(req_push_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pop_value (rsp_pop_value),
      .rsp_status    (rsp_status),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void reload_tops();
      int unsigned base;
      base = (split_point > DEPTH) ? DEPTH : split_point;
      first_top = 0;
      second_top = base;
      third_top = base;
   endfunction

   function automatic answer_type stack_access(input logic op, input logic [1:0] sel,
                                               input logic [WORD_W-1:0] value);
      answer_type a;
      int unsigned base;
      base = (split_point > DEPTH) ? DEPTH : split_point;
      a.pop_value = MINUS_ONE;
      if (op == OP_PUSH) begin
         a.status = ST_FULL;
         case (sel)
            SEL_FIRST: if (first_top < second_top && first_top < DEPTH) begin
               word_store[first_top] = value;
               first_top++;
               a.status = ST_OK;
            end
            SEL_SECOND: if (second_top > first_top && second_top > 0) begin
               second_top--;
               if (second_top < DEPTH) word_store[second_top] = value;
               a.status = ST_OK;
            end
            SEL_THIRD: if (third_top < DEPTH) begin
               word_store[third_top] = value;
               third_top++;
               a.status = ST_OK;
            end
            default: ;
         endcase
      end else begin
         a.status = ST_EMPTY;
         case (sel)
            SEL_FIRST: if (first_top > 0) begin
               first_top--;
               if (first_top < DEPTH) a.pop_value = word_store[first_top];
               a.status = ST_OK;
            end
            SEL_SECOND: if (second_top < base) begin
               if (second_top < DEPTH) a.pop_value = word_store[second_top];
               second_top++;
               a.status = ST_OK;
            end
            SEL_THIRD: if (third_top > base) begin
               third_top--;
               if (third_top < DEPTH) a.pop_value = word_store[third_top];
               a.status = ST_OK;
            end
            default: ;
         endcase
      end
      return a;
   endfunction

   // Drive one request word, wait for it to be taken, log what should come back.
   task automatic issue_word(input logic op, input logic [1:0] sel,
                             input logic [WORD_W-1:0] value, input bit typed,
                             input answer_type typed_answer);
      answer_type predicted;
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_stack_sel <= sel;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = stack_access(op, sel, value);
      expected_answers.push_back(typed ? typed_answer : predicted);
   endtask

   task automatic wait_drained();
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_split(input logic [SPLIT_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      split_point = value;
      reload_tops();
   endtask

   // response side: random stall, compare against oldest expectation, watchdog
   always @(posedge clock) begin
      answer_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         rsp_stall <= !reset && rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct;
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected result word: pop_value %0d status %0d",
                      rsp_pop_value, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_pop_value !== want.pop_value) begin
                  $error("pop_value: expected %0d, got %0d",
                         $signed(want.pop_value), rsp_pop_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [SPLIT_W-1:0] phase_splits [8];
      int burst_left;
      int push_pct;
      logic [1:0] burst_sel;
      logic op;
      logic [1:0] sel;
      logic [WORD_W-1:0] value;

      phase_splits = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd30, 5'd2, 5'd0, 5'd0};
      phase_splits[6] = SPLIT_W'($urandom_range(3, 29));
      phase_splits[7] = SPLIT_W'($urandom_range(0, 31));
      burst_left = 0;
      push_pct = 50;
      burst_sel = SEL_FIRST;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_PUSH;
      req_stack_sel <= SEL_FIRST;
      req_push_value <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      split_point = SPLIT_RESET;
      reload_tops();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_SPLIT)
            write_split(directed_steps[i].value[SPLIT_W-1:0]);
         else
            issue_word(directed_steps[i].op, directed_steps[i].sel, directed_steps[i].value,
                       directed_steps[i].kind == STEP_CHECKED, directed_steps[i].answer);
      end

      for (int phase = 0; phase < 8; phase++) begin
         write_split(phase_splits[phase]);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 47; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 47; end
            default: begin req_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // bursts leaning toward push or pop drive stacks to full and back to empty
            if (burst_left == 0) begin
               burst_left = $urandom_range(4, 40);
               burst_sel = 2'($urandom_range(0, 2));
               push_pct = $urandom_range(0, 1) ? 80 : 20;
            end
            burst_left--;
            if ($urandom_range(99) < 5)
               sel = SEL_NONE;
            else if ($urandom_range(99) < 75)
               sel = burst_sel;
            else
               sel = 2'($urandom_range(0, 2));
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            case ($urandom_range(7))
               0: value = 32'h8000_0000;
               1: value = 32'h7fff_ffff;
               2: value = 32'hffff_ffff;
               3: value = 32'h0000_0000;
               default: value = $urandom;
            endcase
            issue_word(op, sel, value, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
